@@ hdl/spag_pkg.sv @@
// shared types, constants and ray geometry for the sliding attack generator
package spag_pkg;

  // ray set selection codes
  localparam logic [1:0] CMD_DIAG = 2'd0;
  localparam logic [1:0] CMD_ORTH = 2'd1;
  localparam logic [1:0] CMD_BOTH = 2'd2;
  localparam logic [1:0] CMD_NONE = 2'd3;

  // board and ray geometry
  localparam int unsigned NumDirs = 8;
  localparam int unsigned RayLen  = 7;
  localparam int unsigned NumDiag = 4;

  // direction codes: diagonals first, then orthogonals
  localparam logic [2:0] DIR_SW = 3'd0;
  localparam logic [2:0] DIR_SE = 3'd1;
  localparam logic [2:0] DIR_NW = 3'd2;
  localparam logic [2:0] DIR_NE = 3'd3;
  localparam logic [2:0] DIR_S  = 3'd4;
  localparam logic [2:0] DIR_W  = 3'd5;
  localparam logic [2:0] DIR_N  = 3'd6;
  localparam logic [2:0] DIR_E  = 3'd7;

  typedef logic [NumDirs-1:0][RayLen-1:0] ray_arr_t;

  // per-ray occupancy and on-board masks, nearest square in bit 0
  typedef struct packed {
    ray_arr_t occ;
    ray_arr_t onb;
    logic     diag_en;
    logic     orth_en;
  } ray_set_t;

  typedef struct packed {
    logic       onboard;
    logic [5:0] sq;
  } target_t;

  // square reached after steps moves from (rank, file) in direction dir
  function automatic target_t ray_target(logic [2:0] rank, logic [2:0] file,
                                         logic [2:0] dir, logic [2:0] steps);
    logic [4:0] r_up, r_dn, f_up, f_dn, r, f;
    target_t    t;
    r_up = {2'b00, rank} + {2'b00, steps};
    r_dn = {2'b00, rank} - {2'b00, steps};
    f_up = {2'b00, file} + {2'b00, steps};
    f_dn = {2'b00, file} - {2'b00, steps};
    case (dir)
      DIR_SW: begin r = r_dn; f = f_dn; end
      DIR_SE: begin r = r_dn; f = f_up; end
      DIR_NW: begin r = r_up; f = f_dn; end
      DIR_NE: begin r = r_up; f = f_up; end
      DIR_S:  begin r = r_dn; f = {2'b00, file}; end
      DIR_W:  begin r = {2'b00, rank}; f = f_dn; end
      DIR_N:  begin r = r_up; f = {2'b00, file}; end
      DIR_E:  begin r = {2'b00, rank}; f = f_up; end
      default: begin r = {2'b00, rank}; f = {2'b00, file}; end
    endcase
    // underflow wraps to large values, so both cases fall off the board
    t.onboard = (r[4:3] == 2'b00) && (f[4:3] == 2'b00);
    t.sq      = {r[2:0], f[2:0]};
    return t;
  endfunction

endpackage

@@ hdl/spag_in_if.sv @@
// request channel: command, origin square and occupancy word
interface spag_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [5:0]  square;
  logic [63:0] occupancy;

  modport source (output valid, command, square, occupancy, input ready);
  modport sink   (input valid, command, square, occupancy, output ready);
endinterface

@@ hdl/spag_out_if.sv @@
// result channel: attack map word
interface spag_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] attacks;

  modport source (output valid, attacks, input ready);
  modport sink   (input valid, attacks, output ready);
endinterface

@@ hdl/sliding_piece_attack_generator.sv @@
// top level: three-stage sliding piece attack map pipeline
//
//  channel  dir  payload                          handshake
//  in_i     in   command[1:0] square[5:0] occ[63:0] valid/ready
//  out_o    out  attacks[63:0]                    valid/ready
//
// one word per cycle sustained while out_o.ready is high; the stages are gather, reach, scatter
// gather reads the occupancy bits under all eight rays, reach runs the blocker scan,
// scatter maps the ray bits back onto the board into the output register
// reset clears only the stage valid bits
// each stage advances when the one after it is empty or moving, so bubbles collapse
module sliding_piece_attack_generator
  import spag_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  spag_in_if.sink    in_i,
  spag_out_if.source out_o
);

  logic       s1_v_q, s2_v_q, out_v_q;
  logic       en_s1, en_s2, en_out;
  ray_set_t   ray_set_d, ray_set_q;
  logic [5:0] s1_sq_q, s2_sq_q;
  logic [1:0] s1_cmd_q;
  ray_arr_t   reach_d, s2_reach_q;
  logic [63:0] attacks_d, attacks_q;

  // stall chain
  assign en_out     = ~out_v_q | out_o.ready;
  assign en_s2      = ~s2_v_q | en_out;
  assign en_s1      = ~s1_v_q | en_s2;
  assign in_i.ready = en_s1;

  // gather: occupancy and on-board mask for each ray step
  always_comb begin
    target_t t;
    ray_set_d = '0;
    for (int d = 0; d < NumDirs; d++) begin
      for (int k = 0; k < RayLen; k++) begin
        t = ray_target(in_i.square[5:3], in_i.square[2:0], 3'(d), 3'(k + 1));
        ray_set_d.onb[d][k] = t.onboard;
        ray_set_d.occ[d][k] = t.onboard & in_i.occupancy[t.sq];
      end
    end
    ray_set_d.diag_en = (in_i.command == CMD_DIAG) || (in_i.command == CMD_BOTH);
    ray_set_d.orth_en = (in_i.command == CMD_ORTH) || (in_i.command == CMD_BOTH);
  end

  // reach: blocker scan
  spag_ray_reach u_reach (
    .ray_set_i (ray_set_q),
    .reach_o   (reach_d)
  );

  // scatter: ray bits back onto the board
  always_comb begin
    target_t t;
    attacks_d = '0;
    for (int d = 0; d < NumDirs; d++) begin
      for (int k = 0; k < RayLen; k++) begin
        t = ray_target(s2_sq_q[5:3], s2_sq_q[2:0], 3'(d), 3'(k + 1));
        if (s2_reach_q[d][k]) begin
          attacks_d[t.sq] = 1'b1;
        end
      end
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_v_q <= in_i.valid;
      end
      if (en_s2) begin
        s2_v_q <= s1_v_q;
      end
      if (en_out) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    if (en_s1 && in_i.valid) begin
      ray_set_q <= ray_set_d;
      s1_sq_q   <= in_i.square;
      s1_cmd_q  <= in_i.command;
    end
    if (en_s2 && s1_v_q) begin
      s2_reach_q <= reach_d;
      s2_sq_q    <= s1_sq_q;
    end
    if (en_out && s2_v_q) begin
      attacks_q <= attacks_d;
    end
  end

  assign out_o.valid   = out_v_q;
  assign out_o.attacks = attacks_q;

  // unused command selects no ray at all
  a_none_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && en_s2 && (s1_cmd_q == CMD_NONE)) |=> (s2_reach_q == '0))
    else $error("unused command produced ray bits");

  // origin square never appears in its own attack map
  a_origin_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_v_q && en_out) |=> !attacks_q[$past(s2_sq_q)])
    else $error("origin square marked as attacked");

  // input stalls only when every stage holds a word
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1_v_q && s2_v_q && out_v_q))
    else $error("input stalled with a bubble in the pipeline");

endmodule

@@ hdl/spag_ray_reach.sv @@
// per-ray reach: squares up to and including the first blocker
module spag_ray_reach
  import spag_pkg::*;
(
  input  ray_set_t ray_set_i,
  output ray_arr_t reach_o
);

  // prefix scan along each ray, gated by the selected ray family
  always_comb begin
    logic blocked;
    logic en;
    reach_o = '0;
    for (int d = 0; d < NumDirs; d++) begin
      blocked = 1'b0;
      en      = (d < NumDiag) ? ray_set_i.diag_en : ray_set_i.orth_en;
      for (int k = 0; k < RayLen; k++) begin
        reach_o[d][k] = en & ray_set_i.onb[d][k] & ~blocked;
        blocked       = blocked | ray_set_i.occ[d][k];
      end
    end
  end

endmodule
